### rtl/cpst_pkg.sv
// Package for the charger power state tracker.
// Holds the sample and result word types, state and message codes and field constants.
// No dependencies.
package cpst_pkg;

  typedef enum logic [2:0] {
    PS_INIT     = 3'd0,
    PS_BATT     = 3'd1,
    PS_USB_IDLE = 3'd2,
    PS_CHARGING = 3'd3,
    PS_FULL     = 3'd4
  } pstate_e;

  typedef enum logic [2:0] {
    MSG_NONE         = 3'd0,
    MSG_BATT_ONLY    = 3'd1,
    MSG_USB_CONN     = 3'd2,
    MSG_CHARGING     = 3'd3,
    MSG_FULL         = 3'd4,
    MSG_USB_DISCONN  = 3'd5,
    MSG_CHG_STOPPED  = 3'd6
  } msg_e;

  localparam logic [2:0] PhaseMask     = 3'h7;
  localparam logic [3:0] BusMask       = 4'hF;
  localparam logic [2:0] PhaseDone     = 3'd7;
  localparam logic [2:0] PhaseChgLast  = 3'd4;
  localparam logic [7:0] IntervalReset = 8'd5;

  // Register index of the configuration port
  localparam logic RegUpdateInterval = 1'b0;

  typedef struct packed {
    logic        battery_voltage_ok;
    logic [15:0] input_voltage_mv;
    logic        input_voltage_ok;
    logic [15:0] charge_current_ma;
    logic        charge_current_ok;
    logic [7:0]  status_byte;
    logic        status_ok;
  } cpst_in_t;

  typedef struct packed {
    logic [2:0]  power_state;
    logic        state_changed;
    logic [2:0]  message_code;
    logic        charging_active;
    logic [15:0] reported_current_ma;
    logic [2:0]  charge_phase;
    logic [3:0]  bus_kind;
    logic [1:0]  cloud_updates;
  } cpst_out_t;

  // Tracker state carried from one sample to the next
  typedef struct packed {
    pstate_e     power_state;
    logic [7:0]  tick_count;
    logic        charging;
    logic [15:0] held_current;
  } cpst_state_t;

endpackage

### rtl/cpst_apb.sv
// APB configuration register for the charger power state tracker.
// Holds the periodic update interval. Depends on cpst_pkg.
module cpst_apb
  import cpst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  interval_o
);

  logic [7:0] interval_q;
  logic       hit;

  assign hit    = (paddr[2] == RegUpdateInterval);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
    end else if (psel && penable && pwrite && pready && hit) begin
      interval_q <= pwdata[7:0];
    end
  end

  assign prdata     = hit ? {24'd0, interval_q} : 32'd0;
  assign interval_o = interval_q;

endmodule

### rtl/cpst_eval.sv
// Next-state and result logic for one charger sample.
// Pure combinational; depends on cpst_pkg.
module cpst_eval
  import cpst_pkg::*;
(
  input  cpst_in_t    item_i,
  input  cpst_state_t state_i,
  input  logic [7:0]  interval_i,
  output cpst_state_t state_o,
  output cpst_out_t   res_o
);

  logic [15:0] cur;
  logic [2:0]  phase;
  logic [3:0]  bus;
  logic        usb, chg, full, cur_nz, all_ok, changed, periodic;
  pstate_e     nxt;
  msg_e        msg;
  logic [7:0]  tick_inc;

  always_comb begin
    cur    = item_i.charge_current_ok ? item_i.charge_current_ma : 16'd0;
    phase  = item_i.status_ok ? (item_i.status_byte[7:5] & PhaseMask) : 3'd0;
    bus    = item_i.status_ok ? (item_i.status_byte[4:1] & BusMask) : 4'd0;
    cur_nz = (cur != 16'd0);
    usb    = (item_i.input_voltage_mv != 16'd0);
    chg    = cur_nz || (phase >= 3'd1 && phase <= PhaseChgLast);
    full   = (phase == PhaseDone) && !cur_nz;
    all_ok = item_i.battery_voltage_ok && item_i.input_voltage_ok && item_i.status_ok;

    nxt = state_i.power_state;
    if (all_ok) begin
      priority if (!usb)  nxt = PS_BATT;
      else if (full)      nxt = PS_FULL;
      else if (chg)       nxt = cur_nz ? PS_CHARGING : state_i.power_state;
      else                nxt = PS_USB_IDLE;
    end
    changed = (nxt != state_i.power_state);

    msg = MSG_NONE;
    if (changed) begin
      unique case (nxt)
        PS_BATT:     msg = (state_i.power_state == PS_INIT) ? MSG_BATT_ONLY : MSG_USB_DISCONN;
        PS_USB_IDLE: msg = (state_i.power_state == PS_INIT || state_i.power_state == PS_BATT)
                           ? MSG_USB_CONN : MSG_CHG_STOPPED;
        PS_CHARGING: msg = MSG_CHARGING;
        PS_FULL:     msg = MSG_FULL;
        default:     msg = MSG_NONE;
      endcase
    end

    state_o             = state_i;
    state_o.power_state = nxt;
    if (item_i.charge_current_ok) begin
      state_o.held_current = (item_i.input_voltage_ok && !usb) ? 16'd0 : cur;
    end
    if (item_i.status_ok) begin
      state_o.charging = usb && ((phase != 3'd0 && phase != PhaseDone) || cur_nz);
    end

    // tick counter wraps at 8 bits before the compare
    tick_inc = state_i.tick_count + 8'd1;
    periodic = (tick_inc >= interval_i);
    state_o.tick_count = periodic ? 8'd0 : tick_inc;

    res_o.power_state         = nxt;
    res_o.state_changed       = changed;
    res_o.message_code        = msg;
    res_o.charging_active     = state_o.charging;
    res_o.reported_current_ma = state_o.held_current;
    res_o.charge_phase        = phase;
    res_o.bus_kind            = bus;
    res_o.cloud_updates       = {1'b0, changed} + {1'b0, periodic};
  end

endmodule

### rtl/charger_power_state_tracker.sv
// Charger power state tracker, top level.
// Each accepted word passes the input register, then the result register.
// Throughput: one word per cycle unless out_ready_i stalls; state_q updates once per word.
// Reset: asynchronous active low; state init, counters and flags zero, interval 5,
// both pipeline registers empty.
module charger_power_state_tracker
  import cpst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cpst_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cpst_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        s1_valid_q, out_valid_q, adv;
  cpst_in_t    s1_data_q;
  cpst_out_t   out_q, res;
  cpst_state_t state_q, state_d;
  logic [7:0]  interval;

  cpst_apb u_apb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .interval_o (interval)
  );

  cpst_eval u_eval (
    .item_i     (s1_data_q),
    .state_i    (state_q),
    .interval_i (interval),
    .state_o    (state_d),
    .res_o      (res)
  );

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{power_state: PS_INIT, tick_count: 8'd0, charging: 1'b0,
                       held_current: 16'd0};
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
        if (s1_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (adv && s1_valid_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/cpst_checker.sv
// Port-level checker for the charger power state tracker, bound to the top level.
// Depends on cpst_pkg.
module cpst_checker
  import cpst_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input cpst_out_t out_data_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_change_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.state_changed |-> out_data_o.message_code != MSG_NONE)
    else $error("state change without message");

  a_nochange_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.state_changed |-> out_data_o.message_code == MSG_NONE)
    else $error("message without state change");

  a_change_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.state_changed |-> out_data_o.cloud_updates != 2'd0)
    else $error("state change without update request");

endmodule

bind charger_power_state_tracker cpst_checker u_cpst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
